### sv/ir_pulse_template_matcher_top_assert.svh
// assertion macros for the ir pulse template matcher
`ifndef IR_PULSE_TEMPLATE_MATCHER_TOP_ASSERT_SVH
`define IR_PULSE_TEMPLATE_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define IPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ipm_pkg.sv
// shared types and constants for the ir pulse template matcher
`timescale 1ns / 1ps

package ipm_pkg;

  typedef enum logic [1:0] {
    MODE_ENTRY   = 2'd0,
    MODE_LENGTH  = 2'd1,
    MODE_CAPTURE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_TOLERANCE   = 2'd0,
    REG_MIN_SAMPLES = 2'd1,
    REG_ACTIVE      = 2'd2
  } reg_idx_t;

  localparam logic [15:0] TOLERANCE_RESET   = 16'd100;
  localparam logic [7:0]  MIN_SAMPLES_RESET = 8'd10;
  localparam logic [4:0]  ACTIVE_RESET      = 5'd0;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int PADDR_W     = 4;

  // sample position saturates here
  localparam logic [7:0] POS_MAX = 8'd255;

endpackage

### sv/ipm_tmpl_ram.sv
// template entry memory: one row per pulse position, one lane per template slot
`timescale 1ns / 1ps

module ipm_tmpl_ram #(
  parameter int LANES  = 16,
  parameter int LANE_W = 16,
  parameter int DEPTH  = 128,
  parameter int AW     = 7,
  parameter int LW     = 4
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [LW-1:0]           wlane,
  input  logic [AW-1:0]           waddr,
  input  logic [LANE_W-1:0]       wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [LANES*LANE_W-1:0] rdata
);

  logic [LANES*LANE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane*LANE_W +: LANE_W] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ir_pulse_template_matcher_top.sv
// ir pulse template matcher top level
//
// channel   dir  handshake                  contents
// s_axis    in   tvalid/tready              tuser mode, tdata template or capture, tlast
// m_axis    out  tvalid/tready              tdata match result, one per burst end
// apb       cfg  psel/penable/pready        tolerance, min_samples, active_templates
//
// one request a cycle is taken unless the compare stage is held; after the final capture request
// is taken, its row is read into the compare stage register, then the result into the output register.
// template writes and length writes complete in the cycle they are taken.
// rst is synchronous; it clears lengths, flags, position and registers, not entries.
// a held result stalls input only when a second burst end reaches the compare stage.
`timescale 1ns / 1ps

module ir_pulse_template_matcher_top #(
  parameter int TEMPLATES     = 16,
  parameter int MAX_PULSES    = 128,
  parameter int DURATION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // slot[3:0], entry_index[10:4], entry_length[18:11], duration[34:19], zero fill
  input  logic [ipm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // found[0], matched_slot[4:1], too_short[5], zero fill
  output logic [ipm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ipm_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import ipm_pkg::*;

  localparam int SW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
  localparam int AW = $clog2(MAX_PULSES);
  localparam int LW = $clog2(MAX_PULSES + 1);
  localparam int PW = (LW > 8) ? LW + 1 : 9;
  localparam int CW = (DURATION_BITS > 16) ? DURATION_BITS : 16;

  // configuration registers
  logic [15:0] tolerance;
  logic [7:0]  min_samples;
  logic [4:0]  active_templates;
  logic        cfg_wr;

  // input fields
  mode_t       in_mode;
  logic [3:0]  in_slot;
  logic [6:0]  in_entry_index;
  logic [7:0]  in_entry_length;
  logic [15:0] in_duration;
  logic        in_acc;
  logic        cap_acc;
  logic        entry_we;

  // state
  logic [LW-1:0]        lengths [TEMPLATES];
  logic [TEMPLATES-1:0] mismatch_flags;
  logic [TEMPLATES-1:0] mismatch_flags_next;
  logic [7:0]           sample_pos;

  // compare stage
  logic                           s1_valid;
  logic                           s1_last;
  logic [7:0]                     s1_pos;
  logic [DURATION_BITS-1:0]       s1_dur;
  logic                           s1_adv;
  logic [TEMPLATES*DURATION_BITS-1:0] row;
  logic [TEMPLATES-1:0]           mark;

  // result
  logic        found_next;
  logic [SW-1:0] which_next;
  logic        short_next;
  logic        out_found;
  logic [3:0]  out_slot;
  logic        out_short;

  assign in_mode         = mode_t'(s_axis_tuser);
  assign in_slot         = s_axis_tdata[3:0];
  assign in_entry_index  = s_axis_tdata[10:4];
  assign in_entry_length = s_axis_tdata[18:11];
  assign in_duration     = s_axis_tdata[34:19];

  assign s1_adv        = s1_valid && (!s1_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cap_acc       = in_acc && (in_mode == MODE_CAPTURE);
  assign entry_we      = in_acc && (in_mode == MODE_ENTRY) &&
                         (32'(in_slot) < TEMPLATES) && (32'(in_entry_index) < MAX_PULSES);

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance        <= TOLERANCE_RESET;
      min_samples      <= MIN_SAMPLES_RESET;
      active_templates <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_TOLERANCE:   tolerance        <= pwdata[15:0];
        REG_MIN_SAMPLES: min_samples      <= pwdata[7:0];
        REG_ACTIVE:      active_templates <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_TOLERANCE:   prdata = {16'd0, tolerance};
      REG_MIN_SAMPLES: prdata = {24'd0, min_samples};
      REG_ACTIVE:      prdata = {27'd0, active_templates};
      default:         prdata = 32'd0;
    endcase
  end

  // template lengths, saturated to the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < TEMPLATES; s++) begin
        lengths[s] <= '0;
      end
    end else if (in_acc && (in_mode == MODE_LENGTH) && (32'(in_slot) < TEMPLATES)) begin
      if (32'(in_entry_length) > MAX_PULSES) begin
        lengths[SW'(in_slot)] <= LW'(MAX_PULSES);
      end else begin
        lengths[SW'(in_slot)] <= LW'(in_entry_length);
      end
    end
  end

  // position of the next capture request, used as the row read address
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_pos <= '0;
    end else if (cap_acc) begin
      if (s_axis_tlast) begin
        sample_pos <= '0;
      end else if (sample_pos != POS_MAX) begin
        sample_pos <= sample_pos + 8'd1;
      end
    end
  end

  ipm_tmpl_ram #(
    .LANES  (TEMPLATES),
    .LANE_W (DURATION_BITS),
    .DEPTH  (MAX_PULSES),
    .AW     (AW),
    .LW     (SW)
  ) u_ram (
    .clk   (clk),
    .we    (entry_we),
    .wlane (SW'(in_slot)),
    .waddr (AW'(in_entry_index)),
    .wdata (DURATION_BITS'(in_duration)),
    .re    (cap_acc),
    .raddr (AW'(sample_pos)),
    .rdata (row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc || s1_adv) begin
      s1_valid <= cap_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_acc) begin
      s1_last <= s_axis_tlast;
      s1_pos  <= sample_pos;
      s1_dur  <= DURATION_BITS'(in_duration);
    end
  end

  // per-slot compare of the sample against its template entry
  always_comb begin
    logic [PW-1:0] len_x;
    logic [PW-1:0] pos_x;
    logic [CW-1:0] ref_x;
    logic [CW-1:0] dur_x;
    logic [CW-1:0] diff;
    for (int s = 0; s < TEMPLATES; s++) begin
      len_x = PW'(lengths[s]);
      pos_x = PW'(s1_pos);
      ref_x = CW'(row[s*DURATION_BITS +: DURATION_BITS]);
      dur_x = CW'(s1_dur);
      diff  = (dur_x > ref_x) ? (dur_x - ref_x) : (ref_x - dur_x);
      mark[s] = (len_x >= PW'(2)) && (pos_x < len_x - PW'(1)) && (diff > CW'(tolerance));
    end
  end

  always_comb begin
    mismatch_flags_next = mismatch_flags;
    if (s1_adv) begin
      if (s1_last) begin
        mismatch_flags_next = '0;
      end else begin
        mismatch_flags_next = mismatch_flags | mark;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_flags <= '0;
    end else begin
      mismatch_flags <= mismatch_flags_next;
    end
  end

  // lowest unmarked active slot; no match when the burst is too short
  always_comb begin
    found_next = 1'b0;
    which_next = '0;
    short_next = ({1'b0, s1_pos} + 9'd1) < {1'b0, min_samples};
    for (int s = TEMPLATES - 1; s >= 0; s--) begin
      if ((s < 32'(active_templates)) && !mismatch_flags[s]) begin
        found_next = 1'b1;
        which_next = SW'(s);
      end
    end
    if (short_next) begin
      found_next = 1'b0;
      which_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_found <= found_next;
      out_slot  <= 4'(which_next);
      out_short <= short_next;
    end
  end

  assign m_axis_tdata = {2'b00, out_short, out_slot, out_found};

  `include "ir_pulse_template_matcher_top_assert.svh"

  `IPM_ASSERT_NOW(a_result_exclusive, m_axis_tvalid, !(out_found && out_short),
                  "result marks both found and too short")
  `IPM_ASSERT_NOW(a_slot_zero_unfound, m_axis_tvalid && !out_found, out_slot == 4'd0,
                  "matched slot nonzero without a match")
  `IPM_ASSERT_NOW(a_stall_only_on_end, s1_valid && !s1_adv, s1_last,
                  "compare stage held on a non-final sample")
  `IPM_ASSERT_NEXT(a_burst_end_clears, cap_acc && s_axis_tlast, sample_pos == 8'd0,
                   "sample position not cleared after burst end")

endmodule
